FILE: rtl/core/hws_pkg.sv
// Shared types, widths and constants for heading_to_wheel_speed.
// Holds the arctangent step table used by the CORDIC pipeline.
// No dependencies.
`default_nettype none
package hws_pkg;

	localparam int FORCE_W = 16;
	localparam int SPEED_W = 12;
	localparam int BASE_W  = 10;
	localparam int BAND_W  = 15;
	localparam int XY_W    = 27;
	localparam int Z_W     = 34;
	localparam int Q_W     = 18;
	localparam int ANGLE_W = 17;
	localparam int MAG_W   = 16;
	localparam int DIFF_W  = 15;
	localparam int PROD_W  = BASE_W + DIFF_W;
	localparam int FRAC_SH = 14;
	localparam int ATAN_LEN = 20;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STRAIGHT_BAND = 2'd1;

	localparam logic [BASE_W-1:0] BASE_RESET = 10'd80;
	localparam logic [BAND_W-1:0] BAND_RESET = 15'd1820;

	localparam logic signed [Z_W-1:0] Z_QUARTER  = 34'sd1073741824;
	localparam logic signed [Z_W-1:0] Z_ROUND    = 34'sd32768;
	localparam logic signed [Q_W-1:0] Q_HALF     = 18'sd32768;
	localparam logic signed [Q_W-1:0] Q_TURN     = 18'sd65536;
	localparam logic [MAG_W-1:0]      MAG_QUARTER = 16'd16384;

	typedef enum logic [1:0] {
		BAND_STRAIGHT,
		BAND_SOFT,
		BAND_SPIN
	} band_t;

	function automatic logic signed [Z_W-1:0] atan_step(input int unsigned idx);
		case (idx)
			0:  return 34'sd536870912;
			1:  return 34'sd316933406;
			2:  return 34'sd167458907;
			3:  return 34'sd85004756;
			4:  return 34'sd42667331;
			5:  return 34'sd21354465;
			6:  return 34'sd10679838;
			7:  return 34'sd5340245;
			8:  return 34'sd2670163;
			9:  return 34'sd1335087;
			10: return 34'sd667544;
			11: return 34'sd333772;
			12: return 34'sd166886;
			13: return 34'sd83443;
			14: return 34'sd41722;
			15: return 34'sd20861;
			16: return 34'sd10430;
			17: return 34'sd5215;
			18: return 34'sd2608;
			19: return 34'sd1304;
			default: return '0;
		endcase
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/hws_cordic.sv
// Vectoring CORDIC pipeline: quadrant pre-rotation, then one micro-rotation per stage.
// Depends on hws_pkg for widths and the arctangent table.
`default_nettype none
module hws_cordic import hws_pkg::*; #(
	parameter int STEPS = 14
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic signed [FORCE_W-1:0]  force_x,
	input  wire logic signed [FORCE_W-1:0]  force_y,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic signed [Z_W-1:0]           out_z,
	output logic                            out_zero
);

	localparam int N = (STEPS > ATAN_LEN) ? ATAN_LEN : STEPS;

	logic                  vld_s  [0:N];
	logic                  rdy    [0:N+1];
	logic signed [XY_W-1:0] x_s   [0:N];
	logic signed [XY_W-1:0] y_s   [0:N];
	logic signed [Z_W-1:0]  z_s   [0:N];
	logic                  zero_s [0:N];

	logic signed [XY_W-1:0] fx_w, fy_w, x_pre, y_pre;
	logic signed [Z_W-1:0]  z_pre;

	assign fx_w = {{(XY_W-FORCE_W-8){force_x[FORCE_W-1]}}, force_x, 8'd0};
	assign fy_w = {{(XY_W-FORCE_W-8){force_y[FORCE_W-1]}}, force_y, 8'd0};

	always_comb begin
		x_pre = fx_w;
		y_pre = fy_w;
		z_pre = '0;
		if (fx_w < 0) begin
			if (fy_w >= 0) begin
				x_pre = fy_w;
				y_pre = -fx_w;
				z_pre = Z_QUARTER;
			end else begin
				x_pre = -fy_w;
				y_pre = fx_w;
				z_pre = -Z_QUARTER;
			end
		end
	end

	assign rdy[N+1] = out_ready;
	assign in_ready = rdy[0];

	for (genvar k = 0; k <= N; k++) begin : g_rdy
		assign rdy[k] = !vld_s[k] || rdy[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (rdy[0]) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[0] && in_valid) begin
			x_s[0]    <= x_pre;
			y_s[0]    <= y_pre;
			z_s[0]    <= z_pre;
			zero_s[0] <= (force_x == '0) && (force_y == '0);
		end
	end

	for (genvar k = 1; k <= N; k++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && vld_s[k-1]) begin
				zero_s[k] <= zero_s[k-1];
				if (y_s[k-1] > 0) begin
					x_s[k] <= x_s[k-1] + (y_s[k-1] >>> (k-1));
					y_s[k] <= y_s[k-1] - (x_s[k-1] >>> (k-1));
					z_s[k] <= z_s[k-1] + atan_step(k-1);
				end else begin
					x_s[k] <= x_s[k-1] - (y_s[k-1] >>> (k-1));
					y_s[k] <= y_s[k-1] + (x_s[k-1] >>> (k-1));
					z_s[k] <= z_s[k-1] - atan_step(k-1);
				end
			end
		end
	end

	assign out_valid = vld_s[N];
	assign out_z     = z_s[N];
	assign out_zero  = zero_s[N];

	a_pre_x_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[0] |-> x_s[0] >= 0)
		else $error("pre-rotation left x negative");

	a_first_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[0] && !rdy[0] |=> vld_s[0] && $stable(z_s[0]))
		else $error("stalled pre-rotation stage changed");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[N] && !out_ready |=> vld_s[N] && $stable(z_s[N]))
		else $error("stalled last micro-rotation stage changed");

endmodule
`default_nettype wire

FILE: rtl/core/hws_speed.sv
// Angle rounding, turn band selection, inner wheel scaling and wheel mapping.
// Depends on hws_pkg for widths, constants and band_t.
`default_nettype none
module hws_speed import hws_pkg::*; (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [BASE_W-1:0]          base_speed,
	input  wire logic [BAND_W-1:0]          straight_band,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic signed [Z_W-1:0]      in_z,
	input  wire logic                       in_zero,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic signed [SPEED_W-1:0]       left_speed,
	output logic signed [SPEED_W-1:0]       right_speed
);

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	logic [MAG_W-1:0]         mag_s1;
	logic                     pos_s1;
	band_t                    band_s2, band_s3;
	logic [DIFF_W-1:0]        diff_s2;
	logic [BASE_W-1:0]        base_s2, base_s3;
	logic                     pos_s2, pos_s3;
	logic [PROD_W-1:0]        prod_s3;
	logic signed [SPEED_W-1:0] left_s4, right_s4;

	logic signed [Z_W-1:0]     z_rnd;
	logic signed [Q_W-1:0]     q_raw, q_wrap;
	logic signed [ANGLE_W-1:0] ang;
	logic [ANGLE_W-1:0]        ang_neg;
	logic [MAG_W-1:0]          mag_w;
	band_t                     band_w;
	logic [MAG_W-1:0]          diff_w;
	logic signed [SPEED_W-1:0] b12, soft12, inner_w, outer_w;

	assign rdy_s4   = !vld_s4 || out_ready;
	assign rdy_s3   = !vld_s3 || rdy_s4;
	assign rdy_s2   = !vld_s2 || rdy_s3;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_comb begin
		z_rnd  = in_z + Z_ROUND;
		q_raw  = z_rnd[Z_W-1:16];
		q_wrap = q_raw;
		if (q_raw <= -Q_HALF) begin
			q_wrap = q_raw + Q_TURN;
		end else if (q_raw > Q_HALF) begin
			q_wrap = q_raw - Q_TURN;
		end
		ang = in_zero ? '0 : q_wrap[ANGLE_W-1:0];
		ang_neg = -ang;
		mag_w = ang[ANGLE_W-1] ? ang_neg[MAG_W-1:0] : ang[MAG_W-1:0];
	end

	always_comb begin
		diff_w = MAG_QUARTER - mag_s1;
		if (mag_s1 <= {1'b0, straight_band}) begin
			band_w = BAND_STRAIGHT;
		end else if (mag_s1 > MAG_QUARTER) begin
			band_w = BAND_SPIN;
		end else begin
			band_w = BAND_SOFT;
		end
	end

	always_comb begin
		b12    = {{(SPEED_W-BASE_W){1'b0}}, base_s3};
		soft12 = {1'b0, prod_s3[PROD_W-1:FRAC_SH]};
		case (band_s3)
			BAND_STRAIGHT: begin
				inner_w = b12;
				outer_w = b12;
			end
			BAND_SPIN: begin
				inner_w = -b12;
				outer_w = b12;
			end
			BAND_SOFT: begin
				inner_w = soft12;
				outer_w = (b12 <<< 1) - soft12;
			end
			default: begin
				inner_w = b12;
				outer_w = b12;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= in_valid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
			if (rdy_s4) vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			mag_s1 <= mag_w;
			pos_s1 <= !ang[ANGLE_W-1] && (ang != '0);
		end
		if (rdy_s2 && vld_s1) begin
			band_s2 <= band_w;
			diff_s2 <= diff_w[DIFF_W-1:0];
			base_s2 <= base_speed;
			pos_s2  <= pos_s1;
		end
		if (rdy_s3 && vld_s2) begin
			prod_s3 <= base_s2 * diff_s2;
			band_s3 <= band_s2;
			base_s3 <= base_s2;
			pos_s3  <= pos_s2;
		end
		if (rdy_s4 && vld_s3) begin
			left_s4  <= pos_s3 ? inner_w : outer_w;
			right_s4 <= pos_s3 ? outer_w : inner_w;
		end
	end

	assign out_valid   = vld_s4;
	assign left_speed  = left_s4;
	assign right_speed = right_s4;

	a_mag_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> mag_s1 <= 16'd32768)
		else $error("heading magnitude beyond half turn");

	a_soft_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 && band_s3 == BAND_SOFT |-> prod_s3[PROD_W-1:FRAC_SH] <= {1'b0, base_s3})
		else $error("inner wheel speed exceeds base speed");

	a_mid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && !rdy_s2 |=> vld_s2 && $stable(diff_s2) && $stable(band_s2))
		else $error("stalled band stage changed");

endmodule
`default_nettype wire

FILE: rtl/core/heading_to_wheel_speed.sv
// Top level of heading_to_wheel_speed: configuration registers, CORDIC and speed stages.
// Depends on hws_pkg, hws_cordic and hws_speed.
//
// channel   direction  fields (low bit up)             handshake
// s_axis    in         force_x[15:0], force_y[31:16]   s_tvalid / s_tready
// m_axis    out        left_speed[11:0], right[23:12]  m_tvalid / m_tready
// cfg       in         index 0 base_speed, 1 band      cfg_we, no wait
//
// One transfer per cycle in and out while m_tready holds no stall; stages in order:
// pre-rotation, one stage per micro-rotation, four speed stages.
// arst_n clears all valid bits and restores base_speed 80, straight_band 1820.
// Each stage holds while the next one is full and stalled; bubbles are squeezed out.
`default_nettype none
module heading_to_wheel_speed import hws_pkg::*; #(
	parameter int CORDIC_STEPS = 14
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [31:0]           s_tdata,   // force_x[15:0], force_y[31:16]
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [23:0]                m_tdata,   // left_speed[11:0], right_speed[23:12]
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [BAND_W-1:0]     cfg_wdata
);

	logic [BASE_W-1:0]         base_q;
	logic [BAND_W-1:0]         band_q;
	logic                      cv_valid, cv_ready, cv_zero;
	logic signed [Z_W-1:0]     cv_z;
	logic signed [SPEED_W-1:0] left_w, right_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_RESET;
			band_q <= BAND_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BASE_SPEED:    base_q <= cfg_wdata[BASE_W-1:0];
				REG_STRAIGHT_BAND: band_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	hws_cordic #(
		.STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.force_x   (s_tdata[15:0]),
		.force_y   (s_tdata[31:16]),
		.out_valid (cv_valid),
		.out_ready (cv_ready),
		.out_z     (cv_z),
		.out_zero  (cv_zero)
	);

	hws_speed u_speed (
		.clk           (clk),
		.arst_n        (arst_n),
		.base_speed    (base_q),
		.straight_band (band_q),
		.in_valid      (cv_valid),
		.in_ready      (cv_ready),
		.in_z          (cv_z),
		.in_zero       (cv_zero),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.left_speed    (left_w),
		.right_speed   (right_w)
	);

	assign m_tdata = {right_w, left_w};

endmodule
`default_nettype wire

FILE: verif/heading_to_wheel_speed_tb.sv
// Self-checking testbench for heading_to_wheel_speed: drives random and corner-case force vectors
// and compares each wheel-speed transfer with a CORDIC-based predictor in a scoreboard class.
// Depends on hws_pkg and the heading_to_wheel_speed RTL.
`timescale 1ns / 100ps
module heading_to_wheel_speed_tb;
	import hws_pkg::*;

	localparam int STEPS      = 14;
	localparam int STEPS_USED = (STEPS > ATAN_LEN) ? ATAN_LEN : STEPS;
	localparam int LATENCY    = STEPS + 5;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_PER_PHASE = 140;
	localparam int NUM_PHASES = 6;
	localparam int LONG_HOLD  = 300;
	localparam int PRINT_CAP  = 100;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	class wheel_scoreboard;
		logic [23:0]       speeds_due[$];
		logic [BASE_W-1:0] base;
		logic [BAND_W-1:0] band;
		longint            atan_z[ATAN_LEN];
		int                errors;

		function new();
			base = BASE_RESET;
			band = BAND_RESET;
			errors = 0;
			atan_z = '{536870912, 316933406, 167458907, 85004756, 42667331,
				21354465, 10679838, 5340245, 2670163, 1335087,
				667544, 333772, 166886, 83443, 41722,
				20861, 10430, 5215, 2608, 1304};
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [BAND_W-1:0] val);
			if (idx == REG_BASE_SPEED)
				base = val[BASE_W-1:0];
			else if (idx == REG_STRAIGHT_BAND)
				band = val;
		endfunction

		function int heading_of(logic signed [FORCE_W-1:0] fx, logic signed [FORCE_W-1:0] fy);
			longint x, y, z, t, q, dx, dy;
			x = longint'(fx) * 256;
			y = longint'(fy) * 256;
			z = 0;
			if (fx == 0 && fy == 0)
				return 0;
			if (x < 0) begin
				if (y >= 0) begin
					t = x; x = y; y = -t; z = longint'(Z_QUARTER);
				end else begin
					t = x; x = -y; y = t; z = -longint'(Z_QUARTER);
				end
			end
			for (int i = 0; i < STEPS_USED; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (y > 0) begin
					x += dx; y -= dy; z += atan_z[i];
				end else begin
					x -= dx; y += dy; z -= atan_z[i];
				end
			end
			q = (z + longint'(Z_ROUND)) >>> 16;
			if (q <= -longint'(Q_HALF))
				q += longint'(Q_TURN);
			if (q > longint'(Q_HALF))
				q -= longint'(Q_TURN);
			return int'(q);
		endfunction

		function void note(logic signed [FORCE_W-1:0] fx, logic signed [FORCE_W-1:0] fy);
			int a, mag, b, inner, outer, left, right;
			logic [SPEED_W-1:0] l12, r12;
			a = heading_of(fx, fy);
			mag = (a < 0) ? -a : a;
			b = int'(base);
			if (mag <= int'(band)) begin
				inner = b; outer = b;
			end else if (mag > int'(MAG_QUARTER)) begin
				inner = -b; outer = b;
			end else begin
				inner = (b * (int'(MAG_QUARTER) - mag)) >>> FRAC_SH;
				outer = 2 * b - inner;
			end
			if (a > 0) begin
				left = inner; right = outer;
			end else begin
				left = outer; right = inner;
			end
			l12 = left[SPEED_W-1:0];
			r12 = right[SPEED_W-1:0];
			speeds_due.push_back({r12, l12});
		endfunction

		task report(string msg);
			if (errors < PRINT_CAP)
				$display("mismatch at %0t: %s", $time, msg);
			errors++;
		endtask

		task check(logic [23:0] got);
			logic [23:0] want;
			if (speeds_due.size() == 0) begin
				report($sformatf("unexpected transfer %h", got));
				return;
			end
			want = speeds_due.pop_front();
			if (got[11:0] !== want[11:0])
				report($sformatf("left_speed got %0d want %0d",
					$signed(got[11:0]), $signed(want[11:0])));
			if (got[23:12] !== want[23:12])
				report($sformatf("right_speed got %0d want %0d",
					$signed(got[23:12]), $signed(want[23:12])));
		endtask
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [31:0]          s_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [23:0]          m_tdata;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [BAND_W-1:0]    cfg_wdata;

	wheel_scoreboard book;
	bit  idle_on;
	bit  rx_live;
	int  hold_cycles;
	int  cycle_count;

	heading_to_wheel_speed #(.CORDIC_STEPS(STEPS)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (rx_live && m_tvalid && m_tready)
			book.check(m_tdata);
	end

	function automatic int gap_len();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [FORCE_W-1:0] rand_force();
		logic [FORCE_W-1:0] edges [6];
		edges = '{16'h8000, 16'h8001, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFF};
		case ($urandom_range(0, 7))
			0, 1, 2, 3: return FORCE_W'($urandom);
			4:          return FORCE_W'($signed($urandom_range(0, 16)) - 8);
			5:          return edges[$urandom_range(0, 5)];
			6:          return FORCE_W'($urandom_range(0, 255));
			default:    return FORCE_W'($urandom_range(16'h7000, 16'hFFFF));
		endcase
	endfunction

	// receiver: random stalls, or a long hold when requested
	initial begin
		forever begin
			@(negedge clk);
			if (!rx_live)
				m_tready <= 1'b0;
			else if (hold_cycles > 0) begin
				m_tready <= 1'b0;
				repeat (hold_cycles) @(negedge clk);
				hold_cycles = 0;
				m_tready <= 1'b1;
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat (gap_len()) @(negedge clk);
				m_tready <= 1'b1;
			end else
				m_tready <= 1'b1;
		end
	end

	task send_force(input logic [FORCE_W-1:0] fx, input logic [FORCE_W-1:0] fy);
		int gap;
		gap = (idle_on && $urandom_range(0, 3) == 0) ? gap_len() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {fy, fx};
		do @(posedge clk); while (!s_tready);
		book.note($signed(fx), $signed(fy));
		@(negedge clk);
	endtask

	task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BAND_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		book.set_reg(idx, val);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// hold the input idle until every result is back, then let the pipeline settle
	task drain();
		s_tvalid <= 1'b0;
		while (book.speeds_due.size() != 0) @(negedge clk);
		repeat (LATENCY) @(negedge clk);
	endtask

	task run_corners();
		logic [FORCE_W-1:0] xs [20];
		logic [FORCE_W-1:0] ys [20];
		xs = '{16'h0000, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 16'h8000, 16'h7FFF,
			16'hFFFF, 16'h0000, 16'h0000, 16'h0001, 16'h8000, 16'h7FFF, 16'hFFFF,
			16'h0001, 16'hFFFF, 16'd1000, 16'd1000, 16'hFFFF, 16'h8000};
		ys = '{16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF,
			16'h0000, 16'h0001, 16'hFFFF, 16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF,
			16'h0001, 16'h0001, 16'd180, 16'd170, 16'd1000, 16'h0001};
		foreach (xs[i])
			send_force(xs[i], ys[i]);
	endtask

	initial begin
		logic [BAND_W-1:0] base_set [1:NUM_PHASES];
		logic [BAND_W-1:0] band_set [1:NUM_PHASES];
		book = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		idle_on = 1'b0;
		rx_live = 1'b0;
		hold_cycles = 0;
		cycle_count = 0;
		base_set[1] = 15'd1023;  band_set[1] = 15'd0;
		base_set[2] = 15'd0;     band_set[2] = 15'd16384;
		base_set[3] = 15'd1023;  band_set[3] = 15'h7FFF;
		base_set[4] = 15'h5A5A;  band_set[4] = 15'd16385;
		base_set[5] = BAND_W'($urandom_range(0, 1023));
		band_set[5] = BAND_W'($urandom_range(0, 16384));
		base_set[6] = 15'd80;    band_set[6] = 15'd1820;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		rx_live = 1'b1;

		write_reg(REG_SPARE_A, BAND_W'($urandom));
		write_reg(REG_SPARE_B, BAND_W'($urandom));
		run_corners();
		drain();

		for (int p = 1; p <= NUM_PHASES; p++) begin
			write_reg(REG_BASE_SPEED, base_set[p]);
			write_reg(REG_STRAIGHT_BAND, band_set[p]);
			idle_on = (p != 1);
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				if (p == 2 && n == 40)
					hold_cycles = LONG_HOLD;
				if (p == 4 && n == 70)
					drain();
				send_force(rand_force(), rand_force());
			end
			drain();
		end

		if (book.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
